// ===== rtl/core/bpsc_pkg.sv =====
// Shared types and constants of the transcript best-prefix scorer.
// Used by every module of the block; depends on nothing else.
package bpsc_pkg;

  // Longest transcript tracked; positions and counts saturate against it.
  localparam int MAX_LEN = 65536;
  localparam int IDX_W   = 16;
  localparam int CNT_W   = 17;
  localparam int COEF_W  = 11;

  localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_LEN);

  localparam logic signed [31:0] SCORE_HI_LIMIT = 32'sh7fff_ffff;
  localparam logic signed [31:0] SCORE_LO_LIMIT = 32'sh8000_0000;

  // Transcript symbol codes.
  localparam logic [1:0] SYM_MATCH    = 2'd0;
  localparam logic [1:0] SYM_MISMATCH = 2'd1;
  localparam logic [1:0] SYM_INSERT   = 2'd2;
  localparam logic [1:0] SYM_DELETE   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_MATCH    = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_GAP_OPEN = 2'd2;
  localparam logic [1:0] REG_GAP_EXT  = 2'd3;

  // Scoring coefficients, all two's complement.
  typedef struct packed {
    logic signed [COEF_W-1:0] match_score;
    logic signed [COEF_W-1:0] mismatch_score;
    logic signed [COEF_W-1:0] gap_open_score;
    logic signed [COEF_W-1:0] gap_extend_score;
  } cfg_t;

  // One reported result item.
  typedef struct packed {
    logic              found;
    logic [CNT_W-1:0]  best_subject_count;
    logic [CNT_W-1:0]  best_query_count;
    logic [IDX_W-1:0]  best_position;
    logic signed [31:0] best_score;
  } result_t;

endpackage

// ===== rtl/core/transcript_best_prefix_scorer_unit.sv =====
// Top level of the transcript best-prefix scorer: stream ports, input
// register, coefficient registers. Depends on bpsc_pkg, bpsc_score_core
// and bpsc_out_buf.
//
// The block scans an edit transcript one symbol per item and, on the item
// marked tlast, emits one result item with the best prefix score and where
// it was reached. It accepts one symbol every clock cycle unless s_tready is
// low. An item sits in the input register while the score update (a 33-bit
// saturating add and a signed compare against the best score) runs on it;
// a last symbol's result item enters the result queue as it leaves the input
// register. Results wait in a two-entry queue; s_tready drops only while the
// input register holds a last symbol and both queue entries are occupied.
// Coefficients must be written through cfg_we, cfg_index and cfg_data only
// while no transcript is in flight; the block itself does not enforce it.
module transcript_best_prefix_scorer_unit
  import bpsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Slave side: tdata holds symbol in [1:0]; bits above are zero.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              s_tlast,
  // Master side: tdata holds best_score [31:0], best_position [47:32],
  // best_query_count [64:48], best_subject_count [81:65], zeros above.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [87:0]       m_tdata,
  // tuser holds found in bit 0.
  output logic              m_tuser,
  // Coefficient write port.
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [COEF_W-1:0] cfg_data
);

  cfg_t       cfg;
  logic       in_valid;
  logic [1:0] in_sym;
  logic       in_last;
  logic       advance;
  logic       buf_full;
  result_t    core_res;
  result_t    head;

  // Coefficient registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_score      <= 11'sd1;
      cfg.mismatch_score   <= -11'sd1;
      cfg.gap_open_score   <= -11'sd2;
      cfg.gap_extend_score <= -11'sd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MATCH:    cfg.match_score      <= cfg_data;
        REG_MISMATCH: cfg.mismatch_score   <= cfg_data;
        REG_GAP_OPEN: cfg.gap_open_score   <= cfg_data;
        REG_GAP_EXT:  cfg.gap_extend_score <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register; it moves on unless a last item finds the queue full.
  assign advance  = in_valid && (!in_last || !buf_full);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_sym  <= s_tdata[1:0];
      in_last <= s_tlast;
    end
  end

  bpsc_score_core u_core (
    .clk  (clk),
    .rst  (rst),
    .go   (advance),
    .sym  (in_sym),
    .last (in_last),
    .cfg  (cfg),
    .res  (core_res)
  );

  bpsc_out_buf u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (advance && in_last),
    .push_data  (core_res),
    .full       (buf_full),
    .head_valid (m_tvalid),
    .head_data  (head),
    .pop_ready  (m_tready)
  );

  // Output packing.
  assign m_tdata = {6'd0, head.best_subject_count, head.best_query_count,
                    head.best_position, head.best_score};
  assign m_tuser = head.found;

endmodule

// ===== rtl/core/bpsc_score_core.sv =====
// Running affine-gap score and best-prefix record of the scorer.
// Depends on bpsc_pkg for the coefficient and result types.
module bpsc_score_core
  import bpsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       go,
  input  logic [1:0] sym,
  input  logic       last,
  input  cfg_t       cfg,
  output result_t    res
);

  logic signed [31:0] running_score;
  logic signed [31:0] best_score_reg;
  logic [IDX_W-1:0]   symbol_index;
  logic [IDX_W-1:0]   best_index;
  logic [CNT_W-1:0]   query_count;
  logic [CNT_W-1:0]   subject_count;
  logic [CNT_W-1:0]   best_query;
  logic [CNT_W-1:0]   best_subject;
  logic [1:0]         previous_symbol;
  logic               found_flag;

  logic               is_gap;
  logic               open_en;
  logic signed [11:0] ext12;
  logic signed [11:0] open12;
  logic signed [11:0] inc;
  logic signed [32:0] sum;
  logic signed [31:0] score_next;
  logic [CNT_W-1:0]   query_count_next;
  logic [CNT_W-1:0]   subject_count_next;
  logic [IDX_W-1:0]   symbol_index_next;
  logic               hit;

  // Score increment for this symbol, gap open only on a change of symbol.
  always_comb begin
    is_gap  = (sym == SYM_INSERT) || (sym == SYM_DELETE);
    open_en = is_gap && (symbol_index != '0) && (previous_symbol != sym);
    ext12   = {cfg.gap_extend_score[COEF_W-1], cfg.gap_extend_score};
    open12  = open_en ? {cfg.gap_open_score[COEF_W-1], cfg.gap_open_score} : 12'sd0;
    case (sym)
      SYM_MATCH:    inc = {cfg.match_score[COEF_W-1], cfg.match_score};
      SYM_MISMATCH: inc = {cfg.mismatch_score[COEF_W-1], cfg.mismatch_score};
      default:      inc = ext12 + open12;
    endcase
  end

  // Saturating add to the running score, then the best-so-far compare.
  always_comb begin
    sum = {running_score[31], running_score} + {{21{inc[11]}}, inc};
    if (sum[32] != sum[31]) begin
      score_next = sum[32] ? SCORE_LO_LIMIT : SCORE_HI_LIMIT;
    end else begin
      score_next = sum[31:0];
    end
    hit = (score_next >= best_score_reg);
  end

  // Position and consumed-length counters, each held at its limit.
  always_comb begin
    query_count_next   = query_count;
    subject_count_next = subject_count;
    if (sym != SYM_INSERT && query_count < CNT_LIMIT) begin
      query_count_next = query_count + 1'b1;
    end
    if (sym != SYM_DELETE && subject_count < CNT_LIMIT) begin
      subject_count_next = subject_count + 1'b1;
    end
    symbol_index_next = (symbol_index < IDX_LIMIT) ? symbol_index + 1'b1 : symbol_index;
  end

  // Record as it stands after this symbol; valid as a result on a last item.
  always_comb begin
    res.best_score         = hit ? score_next : best_score_reg;
    res.best_position      = hit ? symbol_index : best_index;
    res.best_query_count   = hit ? query_count_next : best_query;
    res.best_subject_count = hit ? subject_count_next : best_subject;
    res.found              = hit | found_flag;
  end

  // Scan state; a last item returns everything to zero.
  always_ff @(posedge clk) begin
    if (rst || (go && last)) begin
      running_score   <= '0;
      best_score_reg  <= '0;
      symbol_index    <= '0;
      best_index      <= '0;
      query_count     <= '0;
      subject_count   <= '0;
      best_query      <= '0;
      best_subject    <= '0;
      previous_symbol <= '0;
      found_flag      <= 1'b0;
    end else if (go) begin
      running_score   <= score_next;
      symbol_index    <= symbol_index_next;
      query_count     <= query_count_next;
      subject_count   <= subject_count_next;
      previous_symbol <= sym;
      if (hit) begin
        best_score_reg <= score_next;
        best_index     <= symbol_index;
        best_query     <= query_count_next;
        best_subject   <= subject_count_next;
        found_flag     <= 1'b1;
      end
    end
  end

  // The best score starts each transcript at zero and only rises until it ends.
  a_best_nonneg: assert property (@(posedge clk) disable iff (rst)
    best_score_reg >= 0)
    else $error("best score went negative");

  // Without a record every recorded field is still zero.
  a_empty_record: assert property (@(posedge clk) disable iff (rst)
    !found_flag |-> (best_score_reg == 0 && best_query == '0 && best_subject == '0
                     && best_index == '0))
    else $error("record fields set without a found prefix");

  // Counters never pass the transcript length limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    (query_count <= CNT_LIMIT) && (subject_count <= CNT_LIMIT))
    else $error("consumed-length counter past its limit");

endmodule

// ===== rtl/core/bpsc_out_buf.sv =====
// Two-entry result queue that decouples the scorer from the output stream.
// Depends on bpsc_pkg for the result type.
module bpsc_out_buf
  import bpsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    head_valid,
  output result_t head_data,
  input  logic    pop_ready
);

  logic    v0;
  logic    v1;
  result_t data0;
  result_t data1;
  logic    pop;

  assign pop        = v0 && pop_ready;
  assign full       = v1;
  assign head_valid = v0;
  assign head_data  = data0;

  // Occupancy flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else if (pop && push) begin
      v0 <= 1'b1;
    end else if (pop) begin
      v0 <= v1;
      v1 <= 1'b0;
    end else if (push) begin
      v0 <= 1'b1;
      v1 <= v0;
    end
  end

  // Result storage, shifted toward the head on a pop.
  always_ff @(posedge clk) begin
    if (pop) begin
      data0 <= v1 ? data1 : push_data;
      if (push && v1) begin
        data1 <= push_data;
      end
    end else if (push) begin
      if (!v0) begin
        data0 <= push_data;
      end else begin
        data1 <= push_data;
      end
    end
  end

  // The spare slot is only ever used behind an occupied head.
  a_order: assert property (@(posedge clk) disable iff (rst)
    v1 |-> v0)
    else $error("second result slot filled with an empty head");

  // A waiting head result is not lost until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (v0 && !pop_ready) |=> (v0 && $stable(data0)))
    else $error("head result changed while stalled");

endmodule

// ===== sim/bpsc_result_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the transcript best-prefix scorer: watches the symbol,
// result and coefficient ports, predicts each result and compares it.
// Depends on bpsc_pkg for the symbol codes, register indexes and widths.
module bpsc_result_checker
  import bpsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              s_tlast,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [87:0]       m_tdata,
  input  logic              m_tuser,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [COEF_W-1:0] cfg_data,
  output int                mismatch_count,
  output int                reports_pending
);

  // Coefficients as the block should hold them.
  logic signed [COEF_W-1:0] coef_match;
  logic signed [COEF_W-1:0] coef_mismatch;
  logic signed [COEF_W-1:0] coef_open;
  logic signed [COEF_W-1:0] coef_extend;

  // Scan state of the transcript in flight.
  logic signed [31:0] run_score;
  logic signed [31:0] top_score;
  logic [IDX_W-1:0]   sym_pos;
  logic [IDX_W-1:0]   top_pos;
  logic [CNT_W-1:0]   query_used;
  logic [CNT_W-1:0]   subject_used;
  logic [CNT_W-1:0]   top_query;
  logic [CNT_W-1:0]   top_subject;
  logic [1:0]         prev_sym;
  logic               reached_nonneg;

  // Predicted results, oldest first.
  result_t predicted_reports[$];

  result_t            want;
  logic signed [31:0] got_score;
  logic [IDX_W-1:0]   got_pos;
  logic [CNT_W-1:0]   got_query;
  logic [CNT_W-1:0]   got_subject;
  int                 report_index;

  initial begin
    mismatch_count  = 0;
    reports_pending = 0;
    report_index    = 0;
  end

  // One line per mismatch; printing stops after a hundred but counting goes on.
  task automatic report_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("checker: %s", msg);
    end
    mismatch_count++;
  endtask

  task automatic clear_scan();
    run_score      = '0;
    top_score      = '0;
    sym_pos        = '0;
    top_pos        = '0;
    query_used     = '0;
    subject_used   = '0;
    top_query      = '0;
    top_subject    = '0;
    prev_sym       = SYM_MATCH;
    reached_nonneg = 1'b0;
  endtask

  // Advance the scan by one symbol and queue a result when it ends the transcript.
  task automatic score_symbol(input logic [1:0] sym, input logic ends_here);
    longint  acc;
    result_t rec;
    acc = run_score;
    case (sym)
      SYM_MATCH:    acc += coef_match;
      SYM_MISMATCH: acc += coef_mismatch;
      default: begin
        acc += coef_extend;
        // A gap that follows a different symbol opens a new gap run.
        if (sym_pos != '0 && prev_sym != sym) begin
          acc += coef_open;
        end
      end
    endcase
    if (acc > longint'(SCORE_HI_LIMIT)) begin
      acc = SCORE_HI_LIMIT;
    end
    if (acc < longint'(SCORE_LO_LIMIT)) begin
      acc = SCORE_LO_LIMIT;
    end
    run_score = acc[31:0];

    // Counts stop at the longest tracked transcript.
    if (sym != SYM_INSERT && query_used != CNT_LIMIT) begin
      query_used++;
    end
    if (sym != SYM_DELETE && subject_used != CNT_LIMIT) begin
      subject_used++;
    end

    // Ties move the record forward to the later symbol.
    if (run_score >= top_score) begin
      top_score      = run_score;
      top_pos        = sym_pos;
      top_query      = query_used;
      top_subject    = subject_used;
      reached_nonneg = 1'b1;
    end

    prev_sym = sym;
    if (sym_pos != IDX_LIMIT) begin
      sym_pos++;
    end

    if (ends_here) begin
      rec.best_score         = top_score;
      rec.best_position      = top_pos;
      rec.best_query_count   = top_query;
      rec.best_subject_count = top_subject;
      rec.found              = reached_nonneg;
      predicted_reports      = {predicted_reports, rec};
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      coef_match    = 11'sd1;
      coef_mismatch = -11'sd1;
      coef_open     = -11'sd2;
      coef_extend   = -11'sd1;
      clear_scan();
      predicted_reports.delete();
    end else begin
      // Coefficient writes only happen while no transcript is in flight.
      if (cfg_we) begin
        case (cfg_index)
          REG_MATCH:    coef_match    = cfg_data;
          REG_MISMATCH: coef_mismatch = cfg_data;
          REG_GAP_OPEN: coef_open     = cfg_data;
          REG_GAP_EXT:  coef_extend   = cfg_data;
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        score_symbol(s_tdata[1:0], s_tlast);
      end

      // Compare each result item with the oldest prediction, field by field.
      if (m_tvalid && m_tready) begin
        got_score   = m_tdata[31:0];
        got_pos     = m_tdata[47:32];
        got_query   = m_tdata[64:48];
        got_subject = m_tdata[81:65];
        if (predicted_reports.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected",
                                    report_index));
        end else begin
          want = predicted_reports.pop_front();
          if (got_score !== want.best_score) begin
            report_mismatch($sformatf("result %0d best_score got %0d expected %0d",
                                      report_index, got_score, want.best_score));
          end
          if (got_pos !== want.best_position) begin
            report_mismatch($sformatf("result %0d best_position got %0d expected %0d",
                                      report_index, got_pos, want.best_position));
          end
          if (got_query !== want.best_query_count) begin
            report_mismatch($sformatf("result %0d best_query_count got %0d expected %0d",
                                      report_index, got_query, want.best_query_count));
          end
          if (got_subject !== want.best_subject_count) begin
            report_mismatch($sformatf("result %0d best_subject_count got %0d expected %0d",
                                      report_index, got_subject, want.best_subject_count));
          end
          if (m_tuser !== want.found) begin
            report_mismatch($sformatf("result %0d found got %b expected %b",
                                      report_index, m_tuser, want.found));
          end
        end
        report_index++;
      end
    end
    reports_pending = predicted_reports.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// Top of the transcript best-prefix scorer testbench: clock, reset, symbol
// and coefficient stimulus, result back-pressure and the verdict.
// Depends on bpsc_pkg, transcript_best_prefix_scorer_unit and bpsc_result_checker.
module tb_top;
  import bpsc_pkg::*;

  localparam int ITEM_TARGET = 1100;
  localparam int RX_HOLD     = 300;
  // A longer run of alternating gaps at the largest gap scores, so that every
  // gap after the first opens a new run and the score climbs on each symbol.
  localparam int LONG_GAPS   = 48;
  localparam int CYCLE_LIMIT = 4000000;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;
  logic              s_tlast;
  logic              m_tvalid;
  logic              m_tready;
  logic [87:0]       m_tdata;
  logic              m_tuser;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [COEF_W-1:0] cfg_data;

  int mismatch_count;
  int reports_pending;
  int cycle_count;
  int items_sent;
  bit tx_eager;
  bit rx_eager;
  bit rx_hold_req;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  transcript_best_prefix_scorer_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bpsc_result_checker result_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .reports_pending (reports_pending)
  );

  // Offer one symbol after a random gap (none when tx_eager is set) and wait until it is taken.
  task automatic offer_symbol(input logic [1:0] sym, input logic fin);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {6'b0, sym};
    s_tlast  <= fin;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!(s_tvalid && s_tready)) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Random transcript; half the symbols lean toward one favored symbol so that
  // gap runs and long match stretches both occur.
  task automatic send_transcript(input int len);
    logic [1:0] favored;
    logic [1:0] sym;
    favored = 2'($urandom_range(0, 3));
    for (int k = 0; k < len; k++) begin
      sym = $urandom_range(0, 1) ? favored : 2'($urandom_range(0, 3));
      offer_symbol(sym, k == len - 1);
    end
  endtask

  // Stop offering, wait for every predicted result, then let the pipeline empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (reports_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all four coefficients on consecutive cycles.
  task automatic load_coefs(input logic signed [COEF_W-1:0] m_val,
                            input logic signed [COEF_W-1:0] r_val,
                            input logic signed [COEF_W-1:0] o_val,
                            input logic signed [COEF_W-1:0] e_val);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MATCH;
    cfg_data  <= m_val;
    @(negedge clk);
    cfg_index <= REG_MISMATCH;
    cfg_data  <= r_val;
    @(negedge clk);
    cfg_index <= REG_GAP_OPEN;
    cfg_data  <= o_val;
    @(negedge clk);
    cfg_index <= REG_GAP_EXT;
    cfg_data  <= e_val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Coefficient drawn from the extremes, a small range or the full range.
  function automatic logic signed [COEF_W-1:0] pick_coef(input int style);
    int pick;
    int v;
    case (style)
      0: begin
        pick = $urandom_range(0, 4);
        v = (pick == 0) ? -1024 : (pick == 1) ? 1023 : pick - 3;
      end
      1: v = int'($urandom_range(0, 16)) - 8;
      default: v = int'($urandom_range(0, 2047)) - 1024;
    endcase
    return COEF_W'(v);
  endfunction

  // Result side: random ready gaps, plus one long hold-off when requested.
  initial begin
    int n;
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        n = RX_HOLD;
      end else begin
        n = rx_eager ? 0 : $urandom_range(0, 10);
      end
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!(m_tvalid && m_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int  len;
    int  style;
    bit  pressure_done;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tlast     = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_MATCH;
    cfg_data    = '0;
    tx_eager    = 1'b0;
    rx_eager    = 1'b0;
    rx_hold_req = 1'b0;
    items_sent  = 0;
    pressure_done = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset coefficients: single-symbol transcripts, two that never score
    // zero or more, a gap as the first symbol, gap opens and ties.
    offer_symbol(SYM_MATCH, 1'b1);
    offer_symbol(SYM_MISMATCH, 1'b1);
    offer_symbol(SYM_INSERT, 1'b1);
    offer_symbol(SYM_MATCH, 1'b0);
    offer_symbol(SYM_MATCH, 1'b0);
    offer_symbol(SYM_DELETE, 1'b0);
    offer_symbol(SYM_DELETE, 1'b0);
    offer_symbol(SYM_INSERT, 1'b0);
    offer_symbol(SYM_MISMATCH, 1'b0);
    offer_symbol(SYM_MATCH, 1'b1);
    offer_symbol(SYM_MATCH, 1'b0);
    offer_symbol(SYM_MISMATCH, 1'b0);
    offer_symbol(SYM_MATCH, 1'b0);
    offer_symbol(SYM_MISMATCH, 1'b1);

    // All-zero scores: every prefix ties, so the record follows the last symbol.
    settle();
    load_coefs(11'sd0, 11'sd0, 11'sd0, 11'sd0);
    offer_symbol(SYM_INSERT, 1'b0);
    offer_symbol(SYM_DELETE, 1'b0);
    offer_symbol(SYM_MATCH, 1'b0);
    offer_symbol(SYM_MISMATCH, 1'b1);

    // Extreme coefficients of both signs.
    settle();
    load_coefs(11'sd1023, -11'sd1024, -11'sd1024, -11'sd1024);
    offer_symbol(SYM_DELETE, 1'b0);
    offer_symbol(SYM_INSERT, 1'b0);
    offer_symbol(SYM_MATCH, 1'b1);
    settle();
    load_coefs(-11'sd1024, 11'sd1023, 11'sd1023, 11'sd1023);
    offer_symbol(SYM_MISMATCH, 1'b0);
    offer_symbol(SYM_INSERT, 1'b0);
    offer_symbol(SYM_DELETE, 1'b1);

    // Longer back-to-back transcript of alternating gaps with a rising score.
    settle();
    tx_eager = 1'b1;
    for (int k = 0; k < LONG_GAPS; k++) begin
      offer_symbol((k % 2 == 0) ? SYM_INSERT : SYM_DELETE, 1'b0);
    end
    offer_symbol(SYM_MATCH, 1'b0);
    offer_symbol(SYM_MISMATCH, 1'b1);
    tx_eager = 1'b0;

    // Random phases: new coefficients, then a batch of transcripts.
    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      settle();
      style = $urandom_range(0, 2);
      load_coefs(pick_coef(style), pick_coef(style), pick_coef(style), pick_coef(style));
      tx_eager = ($urandom_range(0, 3) == 0);
      rx_eager = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 10)) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
        send_transcript(len);
      end

      // Once, hold the result side off while short transcripts keep coming,
      // so the result queue fills and the symbol side stalls.
      if (!pressure_done && items_sent > ITEM_TARGET / 2) begin
        pressure_done = 1'b1;
        settle();
        tx_eager    = 1'b1;
        rx_eager    = 1'b0;
        rx_hold_req = 1'b1;
        repeat (40) begin
          send_transcript($urandom_range(1, 3));
        end
      end
    end

    settle();
    if (mismatch_count == 0 && reports_pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
